### rtl/core/vrld_pkg.sv
// ----------------------------------------------------------------------------
// vrld_pkg: shared types and constants for the voxel run-length decoder
// Payload structs, configuration struct, register indexes and status codes.
// ----------------------------------------------------------------------------
package vrld_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [7:0] run_value;
        logic [7:0] run_length;
        logic [1:0] status;
        logic       image_done;
    } run_item_t;

    typedef struct packed {
        logic        mode;
        logic        wide_header;
        logic [31:0] voxel_total;
    } cfg_t;

    // configuration register indexes
    localparam logic [1:0] REG_MODE        = 2'd0;
    localparam logic [1:0] REG_WIDE_HEADER = 2'd1;
    localparam logic [1:0] REG_VOXEL_TOTAL = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_ZERO_LEN   = 2'd1;
    localparam logic [1:0] STATUS_AFTER_FULL = 2'd2;
    localparam logic [1:0] STATUS_SHORT      = 2'd3;

    // header lengths in bytes
    localparam logic [3:0] HDR_PAIR_NARROW = 4'd4;
    localparam logic [3:0] HDR_PAIR_WIDE   = 4'd8;
    localparam logic [3:0] HDR_BIN_NARROW  = 4'd6;
    localparam logic [3:0] HDR_BIN_WIDE    = 4'd10;

    // binary mode escape: long run, no value switch
    localparam logic [7:0] RUN_ESCAPE     = 8'd255;
    localparam logic [7:0] RUN_ESCAPE_LEN = 8'd254;

endpackage

### rtl/core/voxel_run_length_decoder.sv
// ----------------------------------------------------------------------------
// voxel_run_length_decoder: byte-stream run-length decoder for voxel images
// Usage:
//   byte channel (byte_valid/byte_stall/byte_item) takes one compressed byte
//   per transfer, header included; first_byte starts a new image, last_byte
//   ends the stream.
//   run channel (run_valid/run_stall/run_item) gives at most one run per
//   byte: value, clipped length, status and image-done flag.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes mode,
//   wide_header and voxel_total; always ready, write only while idle.
// Path: a byte is registered in the input register and decoded from there;
//   its run is loaded into the output register when the decode step fires,
//   and run_valid rises as that register fills.
// Throughput: one byte per cycle unless run_stall holds a waiting run; the
//   decode step is a single pass through the input register, one add/compare
//   on the voxel count and the result register.
// Reset: all decoder state and configuration clear; no sweep is needed.
// Stall: while run_stall holds a waiting run, the held byte waits in the
//   input register and byte_stall rises once that register is also full.
// ----------------------------------------------------------------------------
module voxel_run_length_decoder #(
    parameter int VOXEL_COUNT_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  vrld_pkg::byte_item_t byte_item,

    output logic                 run_valid,
    input  logic                 run_stall,
    output vrld_pkg::run_item_t  run_item,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    vrld_pkg::cfg_t       cfg_reg;
    logic                 stage_valid_reg;
    vrld_pkg::byte_item_t stage_item_reg;
    logic                 res_valid_reg;
    vrld_pkg::run_item_t  res_item_reg;

    logic                 advance;
    logic                 fire;
    logic                 step_valid;
    vrld_pkg::run_item_t  step_item;

    assign cfg_ready  = 1'b1;
    assign advance    = !res_valid_reg || !run_stall;
    assign fire       = stage_valid_reg && advance;
    assign byte_stall = stage_valid_reg && !advance;
    assign run_valid  = res_valid_reg;
    assign run_item   = res_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_valid)
        begin
            case (cfg_index)
                vrld_pkg::REG_MODE:        cfg_reg.mode        <= cfg_data[0];
                vrld_pkg::REG_WIDE_HEADER: cfg_reg.wide_header <= cfg_data[0];
                vrld_pkg::REG_VOXEL_TOTAL: cfg_reg.voxel_total <= cfg_data;
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (!byte_stall)
                stage_valid_reg <= byte_valid;
            if (advance)
                res_valid_reg <= fire && step_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
            stage_item_reg <= byte_item;
        if (fire && step_valid)
            res_item_reg <= step_item;
    end

    vrld_decode #(
        .VOXEL_COUNT_BITS (VOXEL_COUNT_BITS)
    ) u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .fire         (fire),
        .item         (stage_item_reg),
        .result_valid (step_valid),
        .result       (step_item)
    );

endmodule

### rtl/core/vrld_decode.sv
// ----------------------------------------------------------------------------
// vrld_decode: per-byte decode step and decoder state
// Holds header, value and voxel-count state; works out the result of one
// byte combinationally and updates the state when the byte is taken.
// ----------------------------------------------------------------------------
module vrld_decode #(
    parameter int VOXEL_COUNT_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  vrld_pkg::cfg_t      cfg,
    input  logic                fire,
    input  vrld_pkg::byte_item_t item,
    output logic                result_valid,
    output vrld_pkg::run_item_t result
);

    localparam int N = VOXEL_COUNT_BITS;

    logic [3:0]   header_count_reg,   header_count_next;
    logic [7:0]   first_value_reg,    first_value_next;
    logic [7:0]   second_value_reg,   second_value_next;
    logic         using_second_reg,   using_second_next;
    logic         switch_pending_reg, switch_pending_next;
    logic [7:0]   held_value_reg,     held_value_next;
    logic         pair_half_reg,      pair_half_next;
    logic [N-1:0] voxels_done_reg,    voxels_done_next;
    logic         error_seen_reg,     error_seen_next;

    logic [N-1:0] total;
    logic [3:0]   hlen;

    assign total = N'(cfg.voxel_total);

    always_comb
    begin
        if (cfg.mode)
            hlen = cfg.wide_header ? vrld_pkg::HDR_BIN_WIDE : vrld_pkg::HDR_BIN_NARROW;
        else
            hlen = cfg.wide_header ? vrld_pkg::HDR_PAIR_WIDE : vrld_pkg::HDR_PAIR_NARROW;
    end

    always_comb
    begin
        logic [3:0]   hc;
        logic [7:0]   fv;
        logic [7:0]   sv;
        logic         us;
        logic         sp;
        logic [7:0]   hv;
        logic         ph;
        logic [N-1:0] vd;
        logic         es;
        logic         have_run;
        logic [7:0]   rv;
        logic [7:0]   rl;
        logic [1:0]   st;
        logic [N-1:0] remaining;
        logic [N-1:0] vd_new;
        logic         done;

        // first byte of an image starts from cleared state
        hc = item.first_byte ? 4'd0  : header_count_reg;
        fv = item.first_byte ? 8'd0  : first_value_reg;
        sv = item.first_byte ? 8'd0  : second_value_reg;
        us = item.first_byte ? 1'b0  : using_second_reg;
        sp = item.first_byte ? 1'b0  : switch_pending_reg;
        hv = item.first_byte ? 8'd0  : held_value_reg;
        ph = item.first_byte ? 1'b0  : pair_half_reg;
        vd = item.first_byte ? '0    : voxels_done_reg;
        es = item.first_byte ? 1'b0  : error_seen_reg;

        header_count_next   = hc;
        first_value_next    = fv;
        second_value_next   = sv;
        using_second_next   = us;
        switch_pending_next = sp;
        held_value_next     = hv;
        pair_half_next      = ph;
        voxels_done_next    = vd;
        error_seen_next     = es;

        have_run  = 1'b0;
        rv        = 8'd0;
        rl        = 8'd0;
        st        = vrld_pkg::STATUS_OK;
        remaining = total - vd;
        vd_new    = vd;
        done      = 1'b0;

        if (!es)
        begin
            if (hc < hlen)
            begin
                if (cfg.mode)
                begin
                    if (hc == hlen - 4'd2)
                        first_value_next = item.data_byte;
                    else if (hc == hlen - 4'd1)
                        second_value_next = item.data_byte;
                end
                header_count_next = hc + 4'd1;
                if (item.last_byte && ((hc + 4'd1) < hlen || vd < total))
                begin
                    error_seen_next = 1'b1;
                    have_run        = 1'b1;
                    st              = vrld_pkg::STATUS_SHORT;
                    done            = (vd >= total);
                end
            end
            else if (vd >= total)
            begin
                error_seen_next = 1'b1;
                have_run        = 1'b1;
                st              = vrld_pkg::STATUS_AFTER_FULL;
                done            = 1'b1;
            end
            else
            begin
                if (!cfg.mode)
                begin
                    if (!ph)
                    begin
                        held_value_next = item.data_byte;
                        pair_half_next  = 1'b1;
                    end
                    else
                    begin
                        pair_half_next = 1'b0;
                        have_run       = 1'b1;
                        rv             = hv;
                        rl             = item.data_byte;
                    end
                end
                else
                begin
                    using_second_next = us ^ sp;
                    rv = (us ^ sp) ? sv : fv;
                    if (item.data_byte == vrld_pkg::RUN_ESCAPE)
                    begin
                        rl                  = vrld_pkg::RUN_ESCAPE_LEN;
                        switch_pending_next = 1'b0;
                    end
                    else
                    begin
                        rl                  = item.data_byte;
                        switch_pending_next = 1'b1;
                    end
                    have_run = 1'b1;
                end

                if (have_run)
                begin
                    if (rl == 8'd0)
                        st = vrld_pkg::STATUS_ZERO_LEN;
                    else
                    begin
                        // clip at image end; remaining fits in 8 bits when smaller
                        if (N'(rl) > remaining)
                            rl = remaining[7:0];
                        vd_new = vd + N'(rl);
                    end
                end
                voxels_done_next = vd_new;

                if (st == vrld_pkg::STATUS_OK && item.last_byte && vd_new < total)
                begin
                    st = vrld_pkg::STATUS_SHORT;
                    if (!have_run)
                    begin
                        rv = 8'd0;
                        rl = 8'd0;
                    end
                    have_run = 1'b1;
                end
                if (st != vrld_pkg::STATUS_OK)
                    error_seen_next = 1'b1;
                done = (vd_new >= total);
            end
        end

        result_valid      = have_run;
        result.run_value  = rv;
        result.run_length = rl;
        result.status     = st;
        result.image_done = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg   <= '0;
            first_value_reg    <= '0;
            second_value_reg   <= '0;
            using_second_reg   <= 1'b0;
            switch_pending_reg <= 1'b0;
            held_value_reg     <= '0;
            pair_half_reg      <= 1'b0;
            voxels_done_reg    <= '0;
            error_seen_reg     <= 1'b0;
        end
        else if (fire)
        begin
            header_count_reg   <= header_count_next;
            first_value_reg    <= first_value_next;
            second_value_reg   <= second_value_next;
            using_second_reg   <= using_second_next;
            switch_pending_reg <= switch_pending_next;
            held_value_reg     <= held_value_next;
            pair_half_reg      <= pair_half_next;
            voxels_done_reg    <= voxels_done_next;
            error_seen_reg     <= error_seen_next;
        end
    end

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for voxel_run_length_decoder
// Feeds compressed byte streams in both modes and both header widths, with
// well-formed images, clipped runs, zero lengths, bytes past the image end,
// short streams and noise. A behavioural decoder in the bench predicts each
// run, and every run taken from the block is checked field by field in order.
// ----------------------------------------------------------------------------
module tb;

    localparam logic MODE_PAIR   = 1'b0;
    localparam logic MODE_BINARY = 1'b1;

    localparam int FLAW_NONE  = 0;
    localparam int FLAW_SHORT = 1;
    localparam int FLAW_EXTRA = 2;
    localparam int FLAW_ZERO  = 3;

    localparam int ITEM_TARGET    = 1750;
    localparam int PHASE_ITEMS    = 120;
    localparam int MAX_RUNS       = 40;
    localparam int LONG_HOLD      = 80;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct {
        vrld_pkg::byte_item_t item;
        int                   gap;
    } queued_byte_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 byte_valid = 1'b0;
    logic                 byte_stall;
    vrld_pkg::byte_item_t byte_item = '0;
    logic                 run_valid;
    logic                 run_stall = 1'b0;
    vrld_pkg::run_item_t  run_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [1:0]           cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    queued_byte_t        pending_bytes[$];
    vrld_pkg::run_item_t expected_runs[$];
    int                  gap_count = 0;
    int                  stall_left = 0;
    int                  hold_requests = 0;
    int                  holds_served = 0;
    int                  send_gap_max = 13;
    int                  recv_stall_max = 13;
    int                  sent_items = 0;
    int                  mismatches = 0;
    int                  quiet_cycles = 0;

    // bench copy of the registers and decoder state
    logic        cfg_mode = MODE_PAIR;
    logic        cfg_wide = 1'b0;
    logic [31:0] cfg_total = '0;
    logic [3:0]  hdr_seen;
    logic [7:0]  val_a;
    logic [7:0]  val_b;
    logic [7:0]  pair_value;
    logic        on_b;
    logic        flip_due;
    logic        pair_len_next;
    logic        halted;
    logic [31:0] voxels_out;

    voxel_run_length_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .run_valid  (run_valid),
        .run_stall  (run_stall),
        .run_item   (run_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [3:0] header_bytes();
        if (cfg_mode == MODE_BINARY)
            return cfg_wide ? vrld_pkg::HDR_BIN_WIDE : vrld_pkg::HDR_BIN_NARROW;
        return cfg_wide ? vrld_pkg::HDR_PAIR_WIDE : vrld_pkg::HDR_PAIR_NARROW;
    endfunction

    function automatic void clear_decoder();
        hdr_seen      = '0;
        val_a         = '0;
        val_b         = '0;
        pair_value    = '0;
        on_b          = 1'b0;
        flip_due      = 1'b0;
        pair_len_next = 1'b0;
        halted        = 1'b0;
        voxels_out    = '0;
    endfunction

    // Returns 1 when the byte yields a run; the run is placed in r.
    function automatic bit decode_byte(input vrld_pkg::byte_item_t b,
                                       output vrld_pkg::run_item_t r);
        logic [3:0]  hlen;
        logic [7:0]  rv;
        logic [7:0]  rl;
        logic [1:0]  st;
        logic [31:0] room;
        bit          have_run;
        rv = '0;
        rl = '0;
        st = vrld_pkg::STATUS_OK;
        have_run = 1'b0;
        r = '0;
        if (b.first_byte)
            clear_decoder();
        if (halted)
            return 1'b0;
        hlen = header_bytes();
        if (hdr_seen < hlen)
        begin
            if (cfg_mode == MODE_BINARY)
            begin
                if (hdr_seen == hlen - 4'd2)
                    val_a = b.data_byte;
                else if (hdr_seen == hlen - 4'd1)
                    val_b = b.data_byte;
            end
            hdr_seen = hdr_seen + 4'd1;
            if (b.last_byte && (hdr_seen < hlen || voxels_out < cfg_total))
            begin
                halted = 1'b1;
                r = {8'd0, 8'd0, vrld_pkg::STATUS_SHORT, voxels_out >= cfg_total};
                return 1'b1;
            end
            return 1'b0;
        end
        if (voxels_out >= cfg_total)
        begin
            halted = 1'b1;
            r = {8'd0, 8'd0, vrld_pkg::STATUS_AFTER_FULL, 1'b1};
            return 1'b1;
        end
        if (cfg_mode == MODE_PAIR)
        begin
            if (!pair_len_next)
            begin
                pair_value    = b.data_byte;
                pair_len_next = 1'b1;
            end
            else
            begin
                pair_len_next = 1'b0;
                have_run      = 1'b1;
                rv            = pair_value;
                rl            = b.data_byte;
            end
        end
        else
        begin
            if (flip_due)
                on_b = !on_b;
            rv = on_b ? val_b : val_a;
            // escape code: long run, same value next time
            if (b.data_byte == vrld_pkg::RUN_ESCAPE)
            begin
                rl       = vrld_pkg::RUN_ESCAPE_LEN;
                flip_due = 1'b0;
            end
            else
            begin
                rl       = b.data_byte;
                flip_due = 1'b1;
            end
            have_run = 1'b1;
        end
        if (have_run)
        begin
            if (rl == 8'd0)
                st = vrld_pkg::STATUS_ZERO_LEN;
            else
            begin
                room = cfg_total - voxels_out;
                if ({24'd0, rl} > room)
                    rl = room[7:0];
                voxels_out = voxels_out + {24'd0, rl};
            end
        end
        if (st == vrld_pkg::STATUS_OK && b.last_byte && voxels_out < cfg_total)
        begin
            st       = vrld_pkg::STATUS_SHORT;
            have_run = 1'b1;
        end
        if (!have_run)
            return 1'b0;
        if (st != vrld_pkg::STATUS_OK)
            halted = 1'b1;
        r = {rv, rl, st, voxels_out >= cfg_total};
        return 1'b1;
    endfunction

    // byte sender: one queued byte per transfer after its drawn gap
    always @(posedge clk)
    begin : byte_send
        vrld_pkg::run_item_t predicted;
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            gap_count  <= 0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
            begin
                if (decode_byte(byte_item, predicted))
                    expected_runs.push_back(predicted);
            end
            if (byte_valid && byte_stall)
            begin
                // stalled payload is held as it is
            end
            else if (pending_bytes.size() != 0 && gap_count >= pending_bytes[0].gap)
            begin
                byte_item  <= pending_bytes[0].item;
                byte_valid <= 1'b1;
                gap_count  <= 0;
                void'(pending_bytes.pop_front());
            end
            else
            begin
                byte_valid <= 1'b0;
                if (pending_bytes.size() != 0)
                    gap_count <= gap_count + 1;
            end
        end
    end

    // run receiver: random stall after each transfer, long hold on request
    always @(posedge clk)
    begin : run_receive
        int next_wait;
        if (!rst_n)
        begin
            run_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            next_wait = stall_left;
            if (run_valid && !run_stall)
                next_wait = $urandom_range(0, recv_stall_max);
            if (holds_served != hold_requests)
            begin
                next_wait = LONG_HOLD;
                holds_served <= holds_served + 1;
            end
            if (next_wait > 0)
            begin
                run_stall  <= 1'b1;
                stall_left <= next_wait - 1;
            end
            else
            begin
                run_stall  <= 1'b0;
                stall_left <= 0;
            end
        end
    end

    always @(posedge clk)
    begin : run_check
        vrld_pkg::run_item_t want;
        if (rst_n && run_valid && !run_stall)
        begin
            if (expected_runs.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected run: value %0d length %0d status %0d done %0d",
                             run_item.run_value, run_item.run_length,
                             run_item.status, run_item.image_done);
                mismatches++;
            end
            else
            begin
                want = expected_runs.pop_front();
                if (run_item.run_value !== want.run_value
                    || run_item.run_length !== want.run_length
                    || run_item.status !== want.status
                    || run_item.image_done !== want.image_done)
                begin
                    if (mismatches < 10)
                        $display("run mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 want.run_value, want.run_length, want.status,
                                 want.image_done, run_item.run_value,
                                 run_item.run_length, run_item.status,
                                 run_item.image_done);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((byte_valid && !byte_stall) || (run_valid && !run_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("FAIL voxel_run_length_decoder");
        $finish;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        case (idx)
            vrld_pkg::REG_MODE:        cfg_mode = value[0];
            vrld_pkg::REG_WIDE_HEADER: cfg_wide = value[0];
            vrld_pkg::REG_VOXEL_TOTAL: cfg_total = value;
            default:                   ;
        endcase
    endtask

    task automatic set_config(input logic mode, input logic wide, input logic [31:0] total);
        write_reg(vrld_pkg::REG_MODE, {31'd0, mode});
        write_reg(vrld_pkg::REG_WIDE_HEADER, {31'd0, wide});
        write_reg(vrld_pkg::REG_VOXEL_TOTAL, total);
    endtask

    // sender drained and every run in; then let any silent byte clear the pipe
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || byte_valid || expected_runs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_byte(input vrld_pkg::byte_item_t b);
        queued_byte_t q;
        q.item = b;
        q.gap  = $urandom_range(0, send_gap_max);
        pending_bytes.push_back(q);
        sent_items++;
    endtask

    // One image for the current registers, optionally spoilt.
    task automatic add_image(input int flaw);
        vrld_pkg::byte_item_t img[$];
        vrld_pkg::byte_item_t b;
        longint               left;
        int                   hlen;
        int                   len;
        int                   runs;
        int                   zero_at;
        int                   keep;
        hlen    = header_bytes();
        left    = cfg_total;
        runs    = 0;
        zero_at = $urandom_range(0, 3);
        for (int i = 0; i < hlen; i++)
            img.push_back({8'($urandom), i == 0, 1'b0});
        while (left > 0 && runs < MAX_RUNS)
        begin
            if (cfg_mode == MODE_PAIR)
                img.push_back({8'($urandom), 1'b0, 1'b0});
            case ($urandom_range(0, 7))
                0:       len = 255;
                1:       len = $urandom_range(1, 8);
                default: len = $urandom_range(1, 254);
            endcase
            if (flaw == FLAW_ZERO && runs == zero_at)
                len = 0;
            img.push_back({8'(len), 1'b0, 1'b0});
            left -= (cfg_mode == MODE_BINARY && len == 255) ? 254 : len;
            runs++;
        end
        if (flaw == FLAW_EXTRA)
            repeat ($urandom_range(1, 3)) img.push_back({8'($urandom), 1'b0, 1'b0});
        if (flaw == FLAW_SHORT)
        begin
            keep = $urandom_range(1, img.size() - 1);
            while (img.size() > keep)
                void'(img.pop_back());
        end
        b = img.pop_back();
        b.last_byte = 1'b1;
        img.push_back(b);
        foreach (img[i])
            push_byte(img[i]);
    endtask

    initial
    begin : stimulus
        int          ph;
        int          phase_end;
        int          pick;
        bit          carry;
        logic [31:0] total;
        clear_decoder();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // pair mode: full-scale run, exact fill, then zero length and a silent byte
        set_config(MODE_PAIR, 1'b0, 32'd300);
        push_byte({8'hA5, 1'b1, 1'b0});
        push_byte({8'h00, 1'b0, 1'b0});
        push_byte({8'hFF, 1'b0, 1'b0});
        push_byte({8'h5A, 1'b0, 1'b0});
        push_byte({8'hFF, 1'b0, 1'b0});
        push_byte({8'hFF, 1'b0, 1'b0});
        push_byte({8'h00, 1'b0, 1'b0});
        push_byte({8'd45, 1'b0, 1'b1});
        push_byte({8'h3C, 1'b1, 1'b0});
        push_byte({8'h00, 1'b0, 1'b0});
        push_byte({8'h00, 1'b0, 1'b0});
        push_byte({8'h00, 1'b0, 1'b0});
        push_byte({8'h07, 1'b0, 1'b0});
        push_byte({8'h00, 1'b0, 1'b0});
        push_byte({8'h99, 1'b0, 1'b1});
        wait_idle();

        // binary mode: escape run, switch, clipped run, byte past the end
        set_config(MODE_BINARY, 1'b0, 32'd270);
        push_byte({8'h00, 1'b1, 1'b0});
        push_byte({8'h01, 1'b0, 1'b0});
        push_byte({8'h02, 1'b0, 1'b0});
        push_byte({8'h03, 1'b0, 1'b0});
        push_byte({8'h11, 1'b0, 1'b0});
        push_byte({8'hEE, 1'b0, 1'b0});
        push_byte({8'hFF, 1'b0, 1'b0});
        push_byte({8'h01, 1'b0, 1'b0});
        push_byte({8'h20, 1'b0, 1'b0});
        push_byte({8'h40, 1'b0, 1'b1});

        ph    = 0;
        carry = 1'b0;
        while (sent_items < ITEM_TARGET)
        begin
            wait_idle();
            case (ph % 7)
                2:       total = 32'd0;
                3:       total = $urandom_range(1, 30);
                5:       total = 32'hFFFF_FFFF;
                default: total = $urandom_range(1, 700);
            endcase
            send_gap_max   = (ph % 3 == 1) ? 0 : 13;
            recv_stall_max = (ph % 4 == 2) ? 0 : 13;
            set_config((ph % 2 == 1) ? MODE_BINARY : MODE_PAIR, 1'($urandom_range(0, 1)), total);
            // finish an image whose header began under the previous registers
            if (carry)
            begin
                repeat (7) push_byte({8'($urandom), 1'b0, 1'b0});
                push_byte({8'($urandom), 1'b0, 1'b1});
            end
            phase_end = sent_items + PHASE_ITEMS;
            while (sent_items < phase_end)
            begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0: add_image(FLAW_SHORT);
                    1: add_image(FLAW_EXTRA);
                    2: add_image(FLAW_ZERO);
                    3: repeat ($urandom_range(3, 12))
                           push_byte({8'($urandom), $urandom_range(0, 7) == 0,
                                      $urandom_range(0, 7) == 0});
                    default: add_image(FLAW_NONE);
                endcase
            end
            if (ph == 1)
            begin
                @(posedge clk);
                hold_requests <= hold_requests + 1;
            end
            carry = (ph % 5 == 4);
            if (carry)
            begin
                push_byte({8'($urandom), 1'b1, 1'b0});
                push_byte({8'($urandom), 1'b0, 1'b0});
            end
            ph++;
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_runs.size() == 0)
            $display("PASS voxel_run_length_decoder");
        else
            $display("FAIL voxel_run_length_decoder");
        $finish;
    end

endmodule
